[hw/rtl/trie_pc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trie prefix counter package
// Shared sizes and the command and status bundles between the controller and
// the datapath.
// ----------------------------------------------------------------------------
package trie_pc_pkg;

   // Default configuration of the node pool
   localparam int TPC_NODES       = 4096;
   localparam int TPC_ALPHABET    = 26;
   localparam int TPC_COUNT_WIDTH = 16;

   // Fixed widths of the transaction fields
   localparam int LETTER_W    = 5;
   localparam int RSP_COUNT_W = 16;

   // Command field codes
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_FIND = 1'b1;

   // Status field codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic take;         // accept the request transaction
      logic latch_child;  // capture the child table read
      logic resolve;      // follow, allocate or break on the looked-up child
      logic emit;         // load the response register and close the word
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic walk;         // offered letter needs a child table lookup
      logic produce;      // offered transaction ends in a response without a walk
      logic last_item;    // held transaction carries the last letter
      logic out_free;     // response register can take a new response
   } ctl_stat_type;

endpackage
`default_nettype wire

[hw/rtl/trie_pc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data, read before write.
// ----------------------------------------------------------------------------
module trie_pc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[hw/rtl/trie_pc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trie prefix counter controller
// Sequences accept, child lookup, resolve and response for one letter.
// ----------------------------------------------------------------------------
module trie_pc_ctrl
   import trie_pc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire ctl_stat_type stat,
   output ctl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (stat.walk) begin
                  state_in = ST_READ;
               end else if (stat.produce) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_READ: begin
            cmd.latch_child = 1'b1;
            state_in        = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.resolve = 1'b1;
            state_in    = stat.last_item ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/trie_pc_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trie prefix counter datapath
// Word walk registers, child table, node table and the response register.
// ----------------------------------------------------------------------------
module trie_pc_dpath
   import trie_pc_pkg::*;
#(
   parameter int NODES       = TPC_NODES,
   parameter int ALPHABET    = TPC_ALPHABET,
   parameter int COUNT_WIDTH = TPC_COUNT_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctl_cmd_type            cmd,
   output ctl_stat_type                stat,
   input  wire logic                   req_command,
   input  wire logic [LETTER_W-1:0]    req_letter,
   input  wire logic                   req_last,
   input  wire logic                   req_empty_word,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic      [RSP_COUNT_W-1:0] rsp_prefix_count,
   output logic                        rsp_status
);

   localparam int SLOTS  = NODES * ALPHABET;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int NODE_W = $clog2(NODES);
   localparam int FREE_W = $clog2(NODES + 1);
   localparam int INFO_W = SLOT_W + COUNT_WIDTH;
   localparam int WIDE_W = (COUNT_WIDTH > RSP_COUNT_W) ? COUNT_WIDTH : RSP_COUNT_W;
   localparam int CMP_W  = 9;

   // Word walk state
   logic [NODE_W-1:0]      cursor_ff, cursor_in;
   logic [FREE_W-1:0]      next_free_ff, next_free_in;
   logic                   at_start_ff, at_start_in;
   logic                   broken_ff, broken_in;
   logic                   full_ff, full_in;
   logic [COUNT_WIDTH-1:0] root_count_ff, root_count_in;
   logic [COUNT_WIDTH-1:0] cur_count_ff, cur_count_in;

   // Held transaction and lookup results
   logic                   find_ff, find_in;
   logic                   last_ff, last_in;
   logic                   empty_ff, empty_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [NODE_W-1:0]      child_ff, child_in;
   logic                   plausible_ff, plausible_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_status_ff, rsp_status_in;

   // Memory ports
   logic                   child_we;
   logic [SLOT_W-1:0]      child_addr;
   logic [NODE_W-1:0]      child_wdata, child_rdata;
   logic                   info_we;
   logic [NODE_W-1:0]      info_addr;
   logic [INFO_W-1:0]      info_wdata, info_rdata;

   logic [SLOT_W-1:0]      slot_now;
   logic                   letter_bad;
   logic [SLOT_W-1:0]      info_parent;
   logic [COUNT_WIDTH-1:0] info_count;
   logic [COUNT_WIDTH-1:0] info_bumped;
   logic [COUNT_WIDTH-1:0] one_count;
   logic                   hit;
   logic [WIDE_W-1:0]      root_wide, cur_wide;

   trie_pc_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_child_ram (
      .clock (clock),
      .we    (child_we),
      .addr  (child_addr),
      .wdata (child_wdata),
      .rdata (child_rdata)
   );

   // Each node row holds the slot that points at it and its prefix count
   trie_pc_ram #(.WIDTH(INFO_W), .DEPTH(NODES)) u_info_ram (
      .clock (clock),
      .we    (info_we),
      .addr  (info_addr),
      .wdata (info_wdata),
      .rdata (info_rdata)
   );

   assign slot_now    = SLOT_W'(SLOT_W'(cursor_ff) * SLOT_W'(ALPHABET) + SLOT_W'(req_letter));
   assign letter_bad  = CMP_W'(req_letter) >= CMP_W'(ALPHABET);
   assign info_parent = info_rdata[INFO_W-1 -: SLOT_W];
   assign info_count  = info_rdata[COUNT_WIDTH-1:0];
   assign info_bumped = (&info_count) ? info_count : info_count + COUNT_WIDTH'(1);
   assign one_count   = COUNT_WIDTH'(1);
   // A child entry counts only when its node was allocated since reset from this slot
   assign hit         = plausible_ff && (info_parent == slot_ff);
   assign root_wide   = WIDE_W'(root_count_ff);
   assign cur_wide    = WIDE_W'(cur_count_ff);

   assign stat.walk      = !req_empty_word && !broken_ff && !letter_bad;
   assign stat.produce   = req_empty_word ? (req_command == CMD_FIND) : req_last;
   assign stat.last_item = last_ff;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cursor_in     = cursor_ff;
      next_free_in  = next_free_ff;
      at_start_in   = at_start_ff;
      broken_in     = broken_ff;
      full_in       = full_ff;
      root_count_in = root_count_ff;
      cur_count_in  = cur_count_ff;
      find_in       = find_ff;
      last_in       = last_ff;
      empty_in      = empty_ff;
      slot_in       = slot_ff;
      child_in      = child_ff;
      plausible_in  = plausible_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      child_we      = 1'b0;
      child_addr    = slot_ff;
      child_wdata   = next_free_ff[NODE_W-1:0];
      info_we       = 1'b0;
      info_addr     = child_ff;
      info_wdata    = {slot_ff, info_bumped};

      if (cmd.take) begin
         find_in  = (req_command == CMD_FIND);
         last_in  = req_last;
         empty_in = req_empty_word;
         if (req_empty_word) begin
            // Abandon any word in progress
            cursor_in   = '0;
            at_start_in = 1'b1;
            broken_in   = 1'b0;
            full_in     = 1'b0;
         end else begin
            at_start_in = 1'b0;
            if ((req_command == CMD_ADD) && at_start_ff && !(&root_count_ff)) begin
               root_count_in = root_count_ff + COUNT_WIDTH'(1);
            end
            if (!broken_ff && letter_bad) begin
               broken_in = 1'b1;
            end
            slot_in    = slot_now;
            child_addr = slot_now;
         end
      end

      if (cmd.latch_child) begin
         child_in     = child_rdata;
         plausible_in = (child_rdata != '0) && (FREE_W'(child_rdata) < next_free_ff);
         info_addr    = child_rdata;
      end

      if (cmd.resolve) begin
         if (hit) begin
            cursor_in = child_ff;
            if (find_ff) begin
               cur_count_in = info_count;
            end else begin
               info_we      = 1'b1;
               cur_count_in = info_bumped;
            end
         end else if (find_ff) begin
            broken_in = 1'b1;
         end else if (next_free_ff == FREE_W'(NODES)) begin
            broken_in = 1'b1;
            full_in   = 1'b1;
         end else begin
            // Allocate the next free node with a count of one
            child_we     = 1'b1;
            info_we      = 1'b1;
            info_addr    = next_free_ff[NODE_W-1:0];
            info_wdata   = {slot_ff, one_count};
            cursor_in    = next_free_ff[NODE_W-1:0];
            next_free_in = next_free_ff + FREE_W'(1);
            cur_count_in = one_count;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (empty_ff) begin
            rsp_count_in  = root_wide[RSP_COUNT_W-1:0];
            rsp_status_in = STATUS_OK;
         end else if (find_ff) begin
            rsp_count_in  = broken_ff ? '0 : cur_wide[RSP_COUNT_W-1:0];
            rsp_status_in = STATUS_OK;
         end else begin
            rsp_count_in  = '0;
            rsp_status_in = full_ff ? STATUS_FULL : STATUS_OK;
         end
         cursor_in   = '0;
         at_start_in = 1'b1;
         broken_in   = 1'b0;
         full_in     = 1'b0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         next_free_ff  <= FREE_W'(1);
         at_start_ff   <= 1'b1;
         broken_ff     <= 1'b0;
         full_ff       <= 1'b0;
         root_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cursor_ff     <= cursor_in;
         next_free_ff  <= next_free_in;
         at_start_ff   <= at_start_in;
         broken_ff     <= broken_in;
         full_ff       <= full_in;
         root_count_ff <= root_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_count_ff  <= cur_count_in;
      find_ff       <= find_in;
      last_ff       <= last_in;
      empty_ff      <= empty_in;
      slot_ff       <= slot_in;
      child_ff      <= child_in;
      plausible_ff  <= plausible_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prefix_count = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
`default_nettype wire

[hw/rtl/trie_prefix_counter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trie prefix counter
// Counts words by prefix in a trie held in a fixed pool of nodes.
// ----------------------------------------------------------------------------
// Each request transaction carries one letter of a word, an add or find
// command, a last-letter mark and an empty-word mark. An add walks from the
// root, allocating missing nodes and raising the count of every node it
// visits (counts saturate); a find returns the count of the node reached on
// the last letter, or zero when the path breaks. One response transaction
// comes per finished word (none for an empty add); status reports a pool
// that ran out during the add. A letter that walks the trie goes through
// the steps accept, child table read, then node table read and update. Both
// tables are single-port memories read one after the other, and the next
// letter starts from the node this one reaches. A letter after a broken
// path is accepted without a table read; a word end then loads the response
// register, which holds a response while the next word already starts.
// No clearing pass follows reset: a child entry is trusted only when its
// node was allocated since reset from that very slot, so the block accepts
// transactions straight after reset.
// ----------------------------------------------------------------------------
module trie_prefix_counter_top
   import trie_pc_pkg::*;
#(
   parameter int NODES       = TPC_NODES,
   parameter int ALPHABET    = TPC_ALPHABET,
   parameter int COUNT_WIDTH = TPC_COUNT_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_command,
   input  wire logic [LETTER_W-1:0]    req_letter,
   input  wire logic                   req_last,
   input  wire logic                   req_empty_word,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [RSP_COUNT_W-1:0] rsp_prefix_count,
   output logic                        rsp_status
);

   // Commands from the sequencer, status back from the datapath
   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // Sequence each letter: accept, look up the child, resolve, respond
   trie_pc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the walk state, the node pool and the response register
   trie_pc_dpath #(
      .NODES       (NODES),
      .ALPHABET    (ALPHABET),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_command),
      .req_letter       (req_letter),
      .req_last         (req_last),
      .req_empty_word   (req_empty_word),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_prefix_count (rsp_prefix_count),
      .rsp_status       (rsp_status)
   );

endmodule
`default_nettype wire

[hw/rtl/trie_pc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trie prefix counter checker
// Port-level checks over time, bound to the top level.
// ----------------------------------------------------------------------------
module trie_pc_checker
   import trie_pc_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   req_command,
   input wire logic                   req_empty_word,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [RSP_COUNT_W-1:0] rsp_prefix_count,
   input wire logic                   rsp_status
);

   logic req_fire;
   assign req_fire = req_valid && !req_stall;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prefix_count)
                                 && $stable(rsp_status))
      else $error("stalled response changed");

   // A full pool is reported only by an add, which carries no count
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_prefix_count == '0)
      else $error("full status with nonzero count");

   // Drop an empty add at once: the next transaction is taken right away
   a_empty_add: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_empty_word && (req_command == CMD_ADD) |=> !req_stall)
      else $error("empty add held the request channel");

   // An empty find goes straight to its response
   a_empty_find: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_empty_word && (req_command == CMD_FIND) |=> req_stall)
      else $error("empty find did not move to respond");

   // Reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind trie_prefix_counter_top trie_pc_checker u_checker (.*);
`default_nettype wire

[sim/trie_prefix_counter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie prefix counter testbench
// Drives letter transactions into the trie prefix counter and compares every
// response with an independent model of the node pool held in a scoreboard.
// Runs a directed opening, random word traffic with random sender gaps and
// receiver stalls, and a closing stretch with neither.
// ----------------------------------------------------------------------------
module trie_prefix_counter_top_tb;
   import trie_pc_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_ITEMS  = 780;
   localparam int LIMIT_CYCLES  = 2_000_000;
   localparam int SETTLE_CYCLES = 20;
   localparam int NODE_W        = $clog2(TPC_NODES);
   localparam int COUNT_MAX     = (1 << TPC_COUNT_WIDTH) - 1;
   localparam logic [LETTER_W-1:0] LETTER_Z   = 5'd25;
   localparam logic [LETTER_W-1:0] LETTER_BAD = 5'd31;

   typedef struct packed {
      logic [RSP_COUNT_W-1:0] count;
      logic                   status;
   } word_result_type;

   // Trie model: holds its own node pool and the word walk state, and queues
   // the response each finished word should produce.
   class trie_count_scoreboard;
      bit [NODE_W-1:0] child_of [TPC_NODES*TPC_ALPHABET];
      int unsigned     count_of [TPC_NODES];
      int unsigned     next_free;
      int unsigned     cursor;
      bit              at_start;
      bit              broken;
      bit              full_seen;
      word_result_type expected_q[$];
      int              errors;

      function new();
         next_free = 1;
         errors    = 0;
         close_word();
      endfunction

      function void close_word();
         cursor    = 0;
         at_start  = 1'b1;
         broken    = 1'b0;
         full_seen = 1'b0;
      endfunction

      function void bump(int unsigned node);
         if (node < TPC_NODES && count_of[node] < COUNT_MAX) count_of[node]++;
      endfunction

      // Advance the model by one accepted request transaction.
      function void note_item(logic command, logic [LETTER_W-1:0] letter,
                              logic last, logic empty_word);
         bit              is_find;
         int unsigned     slot;
         int unsigned     nxt;
         word_result_type res;
         is_find = (command == CMD_FIND);
         if (empty_word) begin
            // drop any word in progress; only a find answers
            close_word();
            if (is_find) begin
               res.count  = RSP_COUNT_W'(count_of[0]);
               res.status = STATUS_OK;
               expected_q.push_back(res);
            end
            return;
         end
         if (!is_find && at_start) bump(0);
         at_start = 1'b0;
         if (!broken) begin
            if (32'(letter) >= TPC_ALPHABET || cursor >= TPC_NODES) begin
               broken = 1'b1;
            end else begin
               slot = cursor * TPC_ALPHABET + 32'(letter);
               nxt  = 32'(child_of[slot]);
               if (nxt == 0) begin
                  if (is_find) begin
                     broken = 1'b1;
                  end else if (next_free >= TPC_NODES) begin
                     broken    = 1'b1;
                     full_seen = 1'b1;
                  end else begin
                     nxt = next_free;
                     next_free++;
                     child_of[slot] = NODE_W'(nxt);
                  end
               end
               if (!broken) begin
                  cursor = nxt;
                  if (!is_find) bump(cursor);
               end
            end
         end
         if (!last) return;
         if (is_find) begin
            res.count  = (!broken && cursor < TPC_NODES) ?
                         RSP_COUNT_W'(count_of[cursor]) : '0;
            res.status = STATUS_OK;
         end else begin
            res.count  = '0;
            res.status = full_seen ? STATUS_FULL : STATUS_OK;
         end
         expected_q.push_back(res);
         close_word();
      endfunction

      // Compare one accepted response with the oldest expected one.
      function void check_result(logic [RSP_COUNT_W-1:0] count, logic status);
         word_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with nothing expected: prefix_count %0d status %0d",
                   count, status);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (count !== want.count) begin
            $error("prefix_count: expected %0d, actual %0d", want.count, count);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic                   req_command    = CMD_ADD;
   logic [LETTER_W-1:0]    req_letter     = '0;
   logic                   req_last       = 1'b0;
   logic                   req_empty_word = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [RSP_COUNT_W-1:0] rsp_prefix_count;
   logic                   rsp_status;

   trie_count_scoreboard sb;
   bit quiet       = 1'b0;   // no gaps and no stalls while set
   int burst_left  = 0;
   int items_sent  = 0;
   int stall_left  = 0;
   int stall_pct   = 0;
   int cycle_count = 0;

   trie_prefix_counter_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_letter       (req_letter),
      .req_last         (req_last),
      .req_empty_word   (req_empty_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_prefix_count (rsp_prefix_count),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Cap the run; a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: check each accepted transaction, then pick the next stall.
   // The stall rate changes in stretches, from none up to nearly always.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_prefix_count, rsp_status);
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left <= 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 90;
            endcase
            stall_left = $urandom_range(32, 400);
         end
         stall_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Offer one transaction and hold it until accepted. Valid stays high into
   // the next call unless a gap opens, so it gets one update per edge.
   task automatic send_item(input logic command, input logic [LETTER_W-1:0] letter,
                            input logic last, input logic empty_word);
      int gap;
      if (!quiet && burst_left <= 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 16);
      end
      req_valid      <= 1'b1;
      req_command    <= command;
      req_letter     <= letter;
      req_last       <= last;
      req_empty_word <= empty_word;
      do @(posedge clock); while (req_stall);
      sb.note_item(command, letter, last, empty_word);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_word(input logic command, input int len, input int max_letter);
      for (int i = 0; i < len; i++)
         send_item(command, LETTER_W'($urandom_range(0, max_letter)), i == len - 1, 1'b0);
   endtask

   // Hold the sender idle until every expected response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   // Mostly well-formed words over a narrow alphabet so finds hit shared
   // prefixes; the rest are empty words and broken or mixed words.
   task automatic random_traffic(input int n);
      int   target;
      int   pick;
      int   len;
      logic cmd;
      target = items_sent + n;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            cmd = $urandom_range(0, 1) ? CMD_FIND : CMD_ADD;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            send_word(cmd, len, ($urandom_range(0, 9) == 0) ? 25 : 3);
         end else if (pick < 86) begin
            send_item(1'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)),
                      1'($urandom_range(0, 1)), 1'b1);
         end else begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 9) == 0)
                  // abandon the word with an empty one
                  send_item(1'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)),
                            1'($urandom_range(0, 1)), 1'b1);
               else
                  send_item(1'($urandom_range(0, 1)),
                            ($urandom_range(0, 5) == 0) ? LETTER_W'($urandom_range(26, 31))
                                                        : LETTER_W'($urandom_range(0, 3)),
                            i == len - 1, 1'b0);
            end
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty words, plain words, broken paths, bad
      // letters, an abandoned word and mixed commands.
      send_item(CMD_FIND, 5'd0, 1'b1, 1'b1);       // empty find on a fresh trie
      send_item(CMD_ADD, 5'd5, 1'b0, 1'b1);        // empty add: no response
      send_item(CMD_ADD, LETTER_Z, 1'b1, 1'b0);    // "z"
      send_item(CMD_ADD, 5'd0, 1'b0, 1'b0);        // "ab"
      send_item(CMD_ADD, 5'd1, 1'b1, 1'b0);
      send_item(CMD_FIND, 5'd0, 1'b1, 1'b0);       // find "a"
      send_item(CMD_FIND, 5'd0, 1'b0, 1'b0);       // find "ab"
      send_item(CMD_FIND, 5'd1, 1'b1, 1'b0);
      send_item(CMD_FIND, 5'd0, 1'b0, 1'b0);       // find "abc": path breaks
      send_item(CMD_FIND, 5'd1, 1'b0, 1'b0);
      send_item(CMD_FIND, 5'd2, 1'b1, 1'b0);
      send_item(CMD_ADD, 5'd0, 1'b0, 1'b0);        // add with a bad letter mid-word
      send_item(CMD_ADD, LETTER_BAD, 1'b0, 1'b0);
      send_item(CMD_ADD, 5'd1, 1'b1, 1'b0);
      send_item(CMD_FIND, LETTER_BAD, 1'b1, 1'b0); // find of a bad letter
      send_item(CMD_ADD, 5'd0, 1'b0, 1'b0);        // add abandoned by an empty find
      send_item(CMD_FIND, 5'd0, 1'b1, 1'b1);
      send_item(CMD_FIND, 5'd0, 1'b0, 1'b0);       // word opened by a find, closed by an add
      send_item(CMD_ADD, 5'd2, 1'b1, 1'b0);
      send_item(CMD_ADD, 5'd0, 1'b0, 1'b0);        // word opened by an add, closed by a find
      send_item(CMD_FIND, 5'd3, 1'b1, 1'b0);
      send_item(CMD_FIND, 5'd7, 1'b1, 1'b1);       // empty find: root count

      random_traffic(RANDOM_ITEMS);
      drain();

      // Close with back-to-back traffic and a receiver that never stalls.
      quiet = 1'b1;
      random_traffic(40);
      drain();
      quiet = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
